// ===== sv/med3_pkg.sv =====
// ----------------------------------------------------------------------------
// med3_pkg
// Types and constants shared by the 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package med3_pkg;

  localparam int PIX_W   = 8;
  localparam int WIN_N   = 9;
  localparam int MED_IDX = 4;

  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  // one line store entry: the two rows above the current one
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  // window handoff to the median network
  typedef struct packed {
    logic valid;
    logic last;
  } med_ctl_t;

endpackage

`default_nettype wire

// ===== sv/med3_if.sv =====
// ----------------------------------------------------------------------------
// med3_if
// Stream interfaces for the pixel input and the median result.
// ----------------------------------------------------------------------------
`default_nettype none

interface med3_pix_if
  import med3_pkg::*;
();
  logic valid;
  logic ready;
  pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface med3_res_if
  import med3_pkg::*;
();
  logic valid;
  logic ready;
  pix_t median_out;
  logic last_of_frame;

  modport source (output valid, output median_out, output last_of_frame, input ready);
  modport sink   (input valid, input median_out, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== sv/median_filter_3x3_top.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// 3x3 median filter over a raster pixel stream with one line store for two rows.
// ----------------------------------------------------------------------------
// Path: pixel -> stage 1 -> window -> sort registers a, b -> output register.
// Throughput: one pixel per clock when res is ready; the line store is read and
//   written back once per pixel on separate addresses, so it never stalls the stream.
// Reset: synchronous, restores the 640x480 default and starts at row 0,
//   column 0; line store contents stay undefined until written.
`default_nettype none

module median_filter_3x3_top
  import med3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  med3_pix_if.sink              pix,
  med3_res_if.source            res
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [COL_W-1:0] col;
  logic [FH_W-1:0]  row;
  logic [COL_W-1:0] w_last;
  logic [FH_W-1:0]  h_last;
  logic [31:0]      fw_eff;

  line_t            mem [MAX_WIDTH];
  line_t            rd;

  // stage 1: accepted pixel, line store read in flight
  logic             v1;
  pix_t             px1;
  logic [COL_W-1:0] c1;
  logic             emit1;
  logic             last1;

  // stage 2: window
  win_t             win;
  logic             v2;
  logic             last2;

  logic             en1;
  logic             en2;
  logic             take;
  logic             acc;
  logic             emit;
  logic             at_last;
  med_ctl_t         ctl;

  always_comb begin
    fw_eff = {{(32-FW_W){1'b0}}, frame_width};
    if (fw_eff < 32'd3) begin
      fw_eff = 32'd3;
    end
    if (fw_eff > 32'(MAX_WIDTH)) begin
      fw_eff = 32'(MAX_WIDTH);
    end
    w_last = COL_W'(fw_eff - 32'd1);
    h_last = (frame_height < FH_W'(3)) ? FH_W'(2) : frame_height - FH_W'(1);
  end

  assign en2       = !v2 || take;
  assign en1       = !v1 || en2;
  assign pix.ready = en1;
  assign acc       = pix.valid && en1;
  assign emit      = (row >= FH_W'(2)) && (col >= COL_W'(2));
  assign at_last   = (row == h_last) && (col == w_last);
  assign ctl       = '{valid: v2, last: last2};

  // configuration and raster position; a width or height write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[FW_W-1:0];
          col         <= '0;
          row         <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[FH_W-1:0];
          col          <= '0;
          row          <= '0;
        end
        default: begin
        end
      endcase
    end else if (acc) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + FH_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // line store: read on accept, written back as the stage 1 pixel moves into the window
  always_ff @(posedge clk) begin
    if (en1) begin
      rd <= mem[col];
    end
    if (v1 && en2) begin
      mem[c1] <= '{upper: rd.middle, middle: px1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= acc;
      end
      if (en2) begin
        v2 <= v1 && emit1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px1   <= pix.pixel_in;
      c1    <= col;
      emit1 <= emit;
      last1 <= at_last;
    end
    if (v1 && en2) begin
      // shift window left, new column on the right
      win[0] <= win[1];
      win[1] <= win[2];
      win[3] <= win[4];
      win[4] <= win[5];
      win[6] <= win[7];
      win[7] <= win[8];
      win[2] <= rd.upper;
      win[5] <= rd.middle;
      win[8] <= px1;
      last2  <= last1;
    end
  end

  med3_median u_median (
    .clk  (clk),
    .rst  (rst),
    .win  (win),
    .ctl  (ctl),
    .take (take),
    .res  (res)
  );

  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    v1 && en2 && acc |-> c1 != col)
    else $error("line store read and write back hit the same column");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)
    |=> col == '0 && row == '0)
    else $error("register write did not restart the frame");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    col <= w_last && row <= h_last)
    else $error("position left the frame");

endmodule

`default_nettype wire

// ===== sv/med3_median.sv =====
// ----------------------------------------------------------------------------
// med3_median
// Median of nine as a 19 compare-exchange network over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module med3_median
  import med3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire win_t     win,
  input  wire med_ctl_t ctl,
  output logic          take,
  med3_res_if.source    res
);

  win_t a;
  win_t b;
  win_t a_next;
  win_t b_next;
  win_t c_next;
  logic v3;
  logic v4;
  logic last3;
  logic last4;
  logic en3;
  logic en4;
  logic en_out;

  function automatic win_t cx(win_t v, logic [3:0] lo, logic [3:0] hi);
    win_t r;
    r = v;
    if (v[lo] > v[hi]) begin
      r[lo] = v[hi];
      r[hi] = v[lo];
    end
    return r;
  endfunction

  assign en_out = !res.valid || res.ready;
  assign en4    = !v4 || en_out;
  assign en3    = !v3 || en4;
  assign take   = en3;

  // sort each group of three
  always_comb begin
    a_next = win;
    a_next = cx(a_next, 4'd1, 4'd2);
    a_next = cx(a_next, 4'd4, 4'd5);
    a_next = cx(a_next, 4'd7, 4'd8);
    a_next = cx(a_next, 4'd0, 4'd1);
    a_next = cx(a_next, 4'd3, 4'd4);
    a_next = cx(a_next, 4'd6, 4'd7);
    a_next = cx(a_next, 4'd1, 4'd2);
    a_next = cx(a_next, 4'd4, 4'd5);
    a_next = cx(a_next, 4'd7, 4'd8);
  end

  // max of mins, min of maxes, median of medians
  always_comb begin
    b_next = a;
    b_next = cx(b_next, 4'd0, 4'd3);
    b_next = cx(b_next, 4'd5, 4'd8);
    b_next = cx(b_next, 4'd4, 4'd7);
    b_next = cx(b_next, 4'd3, 4'd6);
    b_next = cx(b_next, 4'd1, 4'd4);
    b_next = cx(b_next, 4'd2, 4'd5);
    b_next = cx(b_next, 4'd4, 4'd7);
  end

  always_comb begin
    c_next = b;
    c_next = cx(c_next, 4'd4, 4'd2);
    c_next = cx(c_next, 4'd6, 4'd4);
    c_next = cx(c_next, 4'd4, 4'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (en3) begin
        v3 <= ctl.valid;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en_out) begin
        res.valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      a     <= a_next;
      last3 <= ctl.last;
    end
    if (en4) begin
      b     <= b_next;
      last4 <= last3;
    end
    if (en_out) begin
      res.median_out    <= c_next[MED_IDX];
      res.last_of_frame <= last4;
    end
  end

  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !en4 |=> v3 && $stable(a) && $stable(last3))
    else $error("stage 3 word lost while stalled");

  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !en_out |=> v4 && $stable(b) && $stable(last4))
    else $error("stage 4 word lost while stalled");

  a_stage4_moves: assert property (@(posedge clk) disable iff (rst)
    v4 && en_out |=> res.valid)
    else $error("stage 4 word did not reach the output");

endmodule

`default_nettype wire
